@@ design/sdepq_pkg.sv @@
// ----------------------------------------------------------------------------
// sdepq_pkg
// shared types and constants for the sorted double-ended priority queue
// ----------------------------------------------------------------------------
package sdepq_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned OPCODE_W       = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned ENTRY_COUNT_W  = 5;
  localparam int unsigned CAPACITY_DEF   = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MIN = 2'd1,
    OP_REMOVE_MAX = 2'd2,
    OP_REMOVE_VAL = 2'd3
  } sdepq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } sdepq_status_e;

  // broadcast command to every cell, already qualified by the controller
  typedef struct packed {
    logic ins;
    logic del_low;
    logic del_high;
    logic del_val;
  } sdepq_cmd_t;

endpackage

@@ design/sdepq_cell.sv @@
// ----------------------------------------------------------------------------
// sdepq_cell
// one slot of the sorted chain: compares against the operand and takes its
// own value, the operand or a neighbour's value
// ----------------------------------------------------------------------------
module sdepq_cell
  import sdepq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sdepq_cmd_t               cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic        [DATA_W-1:0] left_data_i,
  input  logic                     left_valid_i,
  input  logic                     left_lt_i,
  input  logic        [DATA_W-1:0] right_data_i,
  input  logic                     right_valid_i,
  output logic        [DATA_W-1:0] data_o,
  output logic                     valid_o,
  output logic                     lt_o,
  output logic                     eq_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic              valid_q, valid_d;

  assign lt_o = valid_q && ($signed(data_q) < value_i);
  assign eq_o = valid_q && (data_q == DATA_W'(value_i));

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.ins) begin
      valid_d = left_valid_i;
      if (!lt_o) begin
        data_d = left_lt_i ? DATA_W'(value_i) : left_data_i;
      end
    end else if (cmd_i.del_low) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (cmd_i.del_high) begin
      valid_d = valid_q && right_valid_i;
    end else if (cmd_i.del_val) begin
      if (!lt_o) begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

@@ design/sdepq_ends.sv @@
// ----------------------------------------------------------------------------
// sdepq_ends
// picks the lowest and highest occupied entries of the chain
// ----------------------------------------------------------------------------
module sdepq_ends
  import sdepq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic [CAPACITY-1:0][DATA_W-1:0] data_i,
  input  logic [CAPACITY-1:0]             valid_i,
  output logic [DATA_W-1:0]               low_o,
  output logic [DATA_W-1:0]               high_o
);

  logic [CAPACITY-1:0] last_w;

  always_comb begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (i + 1 < CAPACITY) begin
        last_w[i] = valid_i[i] && !valid_i[i+1];
      end else begin
        last_w[i] = valid_i[i];
      end
    end
  end

  always_comb begin
    high_o = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      high_o = high_o | (data_i[i] & {DATA_W{last_w[i]}});
    end
  end

  assign low_o = valid_i[0] ? data_i[0] : '0;

endmodule

@@ design/sorted_double_ended_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue_core
// sorted register chain holding signed values, with insert, remove-min,
// remove-max and remove-value, one status result per transfer
// ----------------------------------------------------------------------------
// pipeline: the result is held in a pending register stage, then in the output registers
// throughput: one operation per cycle while the output does not stall; every cell compares and shifts at once,
//   the chain update is registered on the input transfer, the end values on the move to the output
// reset: count and occupancy bits clear, entry data is not reset
// ----------------------------------------------------------------------------
module sorted_double_ended_priority_queue_core
  import sdepq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic        [OPCODE_W-1:0]      opcode_i,
  input  logic signed [DATA_W-1:0]        value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic        [STATUS_W-1:0]      status_o,
  output logic signed [DATA_W-1:0]        removed_value_o,
  output logic        [ENTRY_COUNT_W-1:0] entry_count_o,
  output logic signed [DATA_W-1:0]        smallest_o,
  output logic signed [DATA_W-1:0]        largest_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0][DATA_W-1:0] data_w;
  logic [CAPACITY-1:0]             valid_w;
  logic [CAPACITY-1:0]             lt_w;
  logic [CAPACITY-1:0]             eq_w;
  logic [CAPACITY-1:0]             first_eq_w;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                p_valid_q;
  sdepq_status_e       p_status_q, status_d;
  logic [DATA_W-1:0]   p_removed_q, removed_d;
  logic                out_valid_q;
  sdepq_status_e       out_status_q;
  logic [DATA_W-1:0]   out_removed_q, out_low_q, out_high_q;
  logic [CNT_W-1:0]    out_count_q;

  logic                accept;
  logic                p_move;
  logic                full;
  logic                empty;
  logic                found;
  sdepq_op_e           op;
  sdepq_cmd_t          cmd;
  logic [DATA_W-1:0]   low_w, high_w;

  assign op     = sdepq_op_e'(opcode_i);
  assign p_move = p_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && !p_move;
  assign accept = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // first entry not below the operand that also equals it
  always_comb begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        first_eq_w[i] = eq_w[i];
      end else begin
        first_eq_w[i] = eq_w[i] && lt_w[i-1];
      end
    end
  end
  assign found = |first_eq_w;

  always_comb begin
    cmd       = '0;
    status_d  = ST_OK;
    removed_d = '0;
    count_d   = count_q;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = accept;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE_MIN: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.del_low = accept;
          removed_d   = low_w;
          count_d     = count_q - CNT_W'(1);
        end
      end
      OP_REMOVE_MAX: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.del_high = accept;
          removed_d    = high_w;
          count_d      = count_q - CNT_W'(1);
        end
      end
      OP_REMOVE_VAL: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          cmd.del_val = accept;
          removed_d   = DATA_W'(value_i);
          count_d     = count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_data, right_data;
    logic              left_valid, left_lt, right_valid;
    if (i == 0) begin : g_head
      // the head always takes the operand when it is not below it
      assign left_data  = '0;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_mid_l
      assign left_data  = data_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_lt    = lt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_data  = data_w[i];
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = data_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    sdepq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .value_i       (value_i),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .left_lt_i     (left_lt),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (data_w[i]),
      .valid_o       (valid_w[i]),
      .lt_o          (lt_w[i]),
      .eq_o          (eq_w[i])
    );
  end

  sdepq_ends #(
    .CAPACITY (CAPACITY)
  ) u_ends (
    .data_i  (data_w),
    .valid_i (valid_w),
    .low_o   (low_w),
    .high_o  (high_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        p_valid_q <= 1'b1;
      end else if (p_move) begin
        p_valid_q <= 1'b0;
      end
      if (p_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_status_q  <= status_d;
      p_removed_q <= removed_d;
    end
    if (p_move) begin
      out_status_q  <= p_status_q;
      out_removed_q <= p_removed_q;
      out_count_q   <= count_q;
      out_low_q     <= low_w;
      out_high_q    <= high_w;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = out_removed_q;
  assign entry_count_o   = ENTRY_COUNT_W'(out_count_q);
  assign smallest_o      = out_low_q;
  assign largest_o       = out_high_q;

  // occupancy bits always agree with the entry count
  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(count_q))
    else $error("occupancy does not match count");

  // an insert into a full store is reported full and leaves the count alone
  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op == OP_INSERT) && full |=> (p_status_q == ST_FULL) && full)
    else $error("insert into full store not dropped");

  // a removal from an empty store reports empty
  a_empty_rm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op != OP_INSERT) && empty |=> (p_status_q == ST_EMPTY) && empty)
    else $error("removal from empty store not flagged");

endmodule

@@ tb/sorted_double_ended_priority_queue_core_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue_core_tb
// self-checking bench for the sorted double-ended priority queue: a short
// table of directed operations (empty and full store, extremes, duplicates,
// missing values) followed by random fill and drain sweeps, with random
// idling on both sides; results are checked against pinned rows or a shadow store
// ----------------------------------------------------------------------------
module sorted_double_ended_priority_queue_core_tb
  import sdepq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP          = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 430;
  localparam int          QUIET_ITEMS  = 60;
  localparam int          IDLE_LIMIT   = 500;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          DRILL_ROWS   = 27;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  typedef struct packed {
    sdepq_status_e                    status;
    logic signed [DATA_W-1:0]         removed;
    logic        [ENTRY_COUNT_W-1:0]  count;
    logic signed [DATA_W-1:0]         smallest;
    logic signed [DATA_W-1:0]         largest;
  } queue_result_t;

  typedef struct packed {
    sdepq_op_e                op;
    logic signed [DATA_W-1:0] val;
    logic                     pinned;
    queue_result_t            res;
  } drill_row_t;

  localparam queue_result_t NO_CHECK = '0;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic        [OPCODE_W-1:0]      opcode_i = OP_INSERT;
  logic signed [DATA_W-1:0]        value_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic        [STATUS_W-1:0]      status_o;
  logic signed [DATA_W-1:0]        removed_value_o;
  logic        [ENTRY_COUNT_W-1:0] entry_count_o;
  logic signed [DATA_W-1:0]        smallest_o;
  logic signed [DATA_W-1:0]        largest_o;

  logic                     pin_now = 1'b0;
  queue_result_t            pin_res = '0;
  bit                       quiet = 1'b0;
  int                       errors = 0;
  logic signed [DATA_W-1:0] ledger[$];
  queue_result_t            pending[$];

  drill_row_t drill [DRILL_ROWS] = '{
    '{OP_REMOVE_MIN, 32'sd0,    1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 32'sd0, 32'sd0}},
    '{OP_REMOVE_MAX, -32'sd1,   1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 32'sd0, 32'sd0}},
    '{OP_REMOVE_VAL, 32'sd5,    1'b1, '{ST_EMPTY, 32'sd0, 5'd0, 32'sd0, 32'sd0}},
    '{OP_INSERT,     MOST_POS,  1'b1, '{ST_OK, 32'sd0, 5'd1, MOST_POS, MOST_POS}},
    '{OP_INSERT,     MOST_NEG,  1'b1, '{ST_OK, 32'sd0, 5'd2, MOST_NEG, MOST_POS}},
    '{OP_REMOVE_VAL, 32'sd1,    1'b1, '{ST_NOT_FOUND, 32'sd0, 5'd2, MOST_NEG, MOST_POS}},
    '{OP_REMOVE_MIN, 32'sd0,    1'b1, '{ST_OK, MOST_NEG, 5'd1, MOST_POS, MOST_POS}},
    '{OP_REMOVE_MAX, 32'sd0,    1'b1, '{ST_OK, MOST_POS, 5'd0, 32'sd0, 32'sd0}},
    '{OP_INSERT,     32'sd3,    1'b0, NO_CHECK},
    '{OP_INSERT,     -32'sd1,   1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd3,    1'b0, NO_CHECK},
    '{OP_INSERT,     MOST_NEG,  1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd100,  1'b0, NO_CHECK},
    '{OP_INSERT,     -32'sd7,   1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd3,    1'b0, NO_CHECK},
    '{OP_INSERT,     MOST_POS,  1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd0,    1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd42,   1'b0, NO_CHECK},
    '{OP_INSERT,     -32'sd100, 1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd8,    1'b0, NO_CHECK},
    '{OP_INSERT,     -32'sd1,   1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd5,    1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd1000, 1'b0, NO_CHECK},
    '{OP_INSERT,     32'sd2,    1'b1, '{ST_OK, 32'sd0, 5'd16, MOST_NEG, MOST_POS}},
    '{OP_INSERT,     32'sd9,    1'b1, '{ST_FULL, 32'sd0, 5'd16, MOST_NEG, MOST_POS}},
    '{OP_REMOVE_VAL, 32'sd3,    1'b0, NO_CHECK},
    '{OP_REMOVE_VAL, MOST_NEG,  1'b0, NO_CHECK}
  };

  sorted_double_ended_priority_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .entry_count_o  (entry_count_o),
    .smallest_o     (smallest_o),
    .largest_o      (largest_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // shadow sorted store, updated on every input transfer
  function automatic queue_result_t apply_op(sdepq_op_e op, logic signed [DATA_W-1:0] v);
    queue_result_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (ledger.size() >= CAP) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < ledger.size() && ledger[pos] < v) pos++;
        ledger.insert(pos, v);
      end
    end else if (ledger.size() == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_REMOVE_MIN) begin
      r.removed = ledger.pop_front();
    end else if (op == OP_REMOVE_MAX) begin
      r.removed = ledger.pop_back();
    end else begin
      pos = 0;
      while (pos < ledger.size() && ledger[pos] != v) pos++;
      if (pos == ledger.size()) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.removed = ledger[pos];
        ledger.delete(pos);
      end
    end
    r.count = ENTRY_COUNT_W'(ledger.size());
    if (ledger.size() != 0) begin
      r.smallest = ledger[0];
      r.largest  = ledger[ledger.size()-1];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1, 2: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
      3: begin
        case ($urandom_range(0, 3))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic send(sdepq_op_e op, logic signed [DATA_W-1:0] v, logic pin,
                      queue_result_t res);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= v;
    pin_now    <= pin;
    pin_res    <= res;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : input_monitor
    queue_result_t predicted;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted = apply_op(sdepq_op_e'(opcode_i), value_i);
      pending.push_back(pin_now ? pin_res : predicted);
    end
  end

  always @(posedge clk_i) begin : result_check
    queue_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        flag_mismatch("transfer with nothing pending", removed_value_o, '0);
      end else begin
        want = pending.pop_front();
        if (status_o !== want.status)
          flag_mismatch("status", DATA_W'(status_o), DATA_W'(want.status));
        if (removed_value_o !== want.removed)
          flag_mismatch("removed_value", removed_value_o, want.removed);
        if (entry_count_o !== want.count)
          flag_mismatch("entry_count", DATA_W'(entry_count_o), DATA_W'(want.count));
        if (smallest_o !== want.smallest) flag_mismatch("smallest", smallest_o, want.smallest);
        if (largest_o !== want.largest) flag_mismatch("largest", largest_o, want.largest);
      end
    end
  end

  initial begin : sink_pacing
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    bit                       filling;
    int                       roll;
    sdepq_op_e                op;
    logic signed [DATA_W-1:0] v;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (drill[k]) send(drill[k].op, drill[k].val, drill[k].pinned, drill[k].res);

    // sweeps between full and empty, with some noise
    filling = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      if (ledger.size() >= CAP && $urandom_range(0, 2) != 0) filling = 1'b0;
      else if (ledger.size() == 0 && $urandom_range(0, 2) != 0) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = !filling;
      v = pick_value();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        op = sdepq_op_e'($urandom_range(0, 3));
      end else if (roll < (filling ? 74 : 30)) begin
        op = OP_INSERT;
      end else begin
        op = sdepq_op_e'($urandom_range(1, 3));
        if (op == OP_REMOVE_VAL && ledger.size() != 0 && $urandom_range(0, 3) != 0)
          v = ledger[$urandom_range(0, ledger.size() - 1)];
      end
      send(op, v, 1'b0, NO_CHECK);
    end
    in_valid_i <= 1'b0;

    while (pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
